@@ hdl/pba_pkg.sv @@
// ----------------------------------------------------------------------------
// pba_pkg
// Shared constants, types and helpers of the page bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

  localparam int unsigned NUM_WORDS          = 32768;
  localparam int unsigned PAGE_SHIFT         = 12;
  localparam int unsigned LOW_RESERVED_PAGES = 256;

  localparam int unsigned WORD_AW        = $clog2(NUM_WORDS);
  localparam int unsigned PAGE_W         = WORD_AW + 5;
  localparam int unsigned TOTAL_PAGES    = NUM_WORDS * 32;
  localparam int unsigned PFN_W          = 64 - PAGE_SHIFT;
  localparam int unsigned LOW_FULL_WORDS = LOW_RESERVED_PAGES / 32;
  localparam int unsigned LOW_TAIL_BITS  = LOW_RESERVED_PAGES % 32;

  localparam logic [31:0] FREE_FLOOR      = 32'h0010_0000;
  localparam logic [31:0] MAP_MIN_BASE    = 32'h0100_0000;
  localparam logic [31:0] MAP_USABLE_TYPE = 32'd1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_MAP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    WOP_FIND_SET  = 2'd0,
    WOP_CLEAR     = 2'd1,
    WOP_SET_RANGE = 2'd2
  } wop_e;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_DECODE = 3'd2,
    S_READ   = 3'd3,
    S_MODIFY = 3'd4,
    S_RESP   = 3'd5
  } state_e;

  typedef struct packed {
    wop_e       op;
    logic [4:0] bit_idx;
    logic [4:0] lo;
    logic [4:0] hi;
  } word_ctl_t;

  // Bitmap word as it stands after reset: low pages marked used.
  function automatic logic [31:0] reset_word(input logic [WORD_AW-1:0] w);
    logic [31:0] tail;
    tail = (32'd1 << 5'(LOW_TAIL_BITS)) - 32'd1;
    if (32'(w) < LOW_FULL_WORDS) begin
      return '1;
    end else if (32'(w) == LOW_FULL_WORDS) begin
      return tail;
    end else begin
      return '0;
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/pba_if.sv @@
// ----------------------------------------------------------------------------
// pba_if
// Request and response channels of the page bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface pba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] page_addr;
  logic [63:0] region_base;
  logic [63:0] region_length;
  logic [31:0] region_type;

  modport source (
    output valid, cmd, page_addr, region_base, region_length, region_type,
    input  ready
  );
  modport sink (
    input  valid, cmd, page_addr, region_base, region_length, region_type,
    output ready
  );
endinterface

interface pba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] alloc_addr;
  logic [1:0]  status;

  modport source (
    output valid, alloc_addr, status,
    input  ready
  );
  modport sink (
    input  valid, alloc_addr, status,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/pba_ram.sv @@
// ----------------------------------------------------------------------------
// pba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/pba_word_unit.sv @@
// ----------------------------------------------------------------------------
// pba_word_unit
// Shared word modifier: first-free search and set, bit clear, range set.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_word_unit (
  input  wire pba_pkg::word_ctl_t ctl_i,
  input  wire logic [31:0]        word_i,
  output logic      [31:0]        word_o,
  output logic                    found_o,
  output logic      [4:0]         found_bit_o
);
  import pba_pkg::*;

  logic [31:0] range_mask;

  // Lowest clear bit wins.
  always_comb begin
    found_o     = 1'b0;
    found_bit_o = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!word_i[i]) begin
        found_o     = 1'b1;
        found_bit_o = 5'(i);
      end
    end
  end

  assign range_mask = ({32{1'b1}} << ctl_i.lo) & ({32{1'b1}} >> (5'd31 - ctl_i.hi));

  always_comb begin
    case (ctl_i.op)
      WOP_FIND_SET:  word_o = word_i | (32'(found_o) << found_bit_o);
      WOP_CLEAR:     word_o = word_i & ~(32'd1 << ctl_i.bit_idx);
      WOP_SET_RANGE: word_o = word_i | range_mask;
      default:       word_o = word_i;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/page_bitmap_allocator.sv @@
// After reset the block runs a clearing pass over the NUM_WORDS words that
// writes the initial bitmap (lowest LOW_RESERVED_PAGES pages used) and takes
// no request meanwhile. Each request then goes through decode, then one RAM
// read and one read-modify-write through the shared word unit for each bitmap
// word it touches, then the response state. Alloc scans word by word from the
// lowest word that may still hold a free page; free touches one word; reserve
// and map walk every word of their range; filtered or empty requests go from
// decode straight to the response. The response sits in an output register and
// the next request is taken as soon as the sequencer is back in idle.
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// First-fit page frame allocator over a used/free bitmap held in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module page_bitmap_allocator (
  input wire logic clk_i,
  input wire logic rst_ni,
  pba_req_if.sink   req_i,
  pba_rsp_if.source rsp_o
);
  import pba_pkg::*;

  state_e state_q, state_d;

  cmd_e        cmd_q;
  logic [31:0] page_addr_q;
  logic [63:0] base_q;
  logic [63:0] len_q;
  logic [31:0] type_q;

  logic [WORD_AW-1:0] word_q, word_d;
  logic [WORD_AW-1:0] first_word_q, first_word_d;
  logic [WORD_AW-1:0] last_word_q, last_word_d;
  logic [4:0]         first_bit_q, first_bit_d;
  logic [4:0]         last_bit_q, last_bit_d;
  logic [WORD_AW:0]   hint_q, hint_d;
  logic [WORD_AW-1:0] clr_q, clr_d;

  logic [31:0] res_addr_q, res_addr_d;
  status_e     res_status_q, res_status_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_addr_q;
  status_e     out_status_q;
  logic        out_load;

  logic               ram_we;
  logic [WORD_AW-1:0] ram_waddr;
  logic [31:0]        ram_wdata;
  logic               ram_re;
  logic [31:0]        ram_rdata;

  word_ctl_t   wu_ctl;
  logic [31:0] wu_word;
  logic        wu_found;
  logic [4:0]  wu_found_bit;

  logic              accept;
  logic [PFN_W-1:0]  first_pfn;
  logic [PFN_W-1:0]  count_pfn;
  logic [PFN_W:0]    end_pfn;
  logic              count_zero;
  logic              first_out;
  logic              end_clip;
  logic [PAGE_W-1:0] last_page;
  logic              map_reject;
  logic [31:0]       free_pfn;
  logic              free_low;
  logic              free_out;
  logic              scan_last;

  assign accept = req_i.valid && req_i.ready;

  // Range decode from the captured request.
  assign first_pfn  = base_q[63:PAGE_SHIFT];
  assign count_pfn  = len_q[63:PAGE_SHIFT];
  assign end_pfn    = {1'b0, first_pfn} + {1'b0, count_pfn};
  assign count_zero = (count_pfn == '0);
  assign first_out  = |first_pfn[PFN_W-1:PAGE_W];
  assign end_clip   = end_pfn[PFN_W] || (end_pfn > (PFN_W+1)'(TOTAL_PAGES));
  assign last_page  = end_clip ? PAGE_W'(TOTAL_PAGES - 1)
                               : PAGE_W'(end_pfn[PAGE_W-1:0] - PAGE_W'(1));
  assign map_reject = (cmd_q == CMD_MAP) &&
                      ((|base_q[63:32]) || (|len_q[63:32]) ||
                       (base_q[31:0] < MAP_MIN_BASE) || (type_q == MAP_USABLE_TYPE));
  assign free_pfn   = page_addr_q >> PAGE_SHIFT;
  assign free_low   = page_addr_q < FREE_FLOOR;
  assign free_out   = free_pfn >= 32'(TOTAL_PAGES);
  assign scan_last  = (word_q == WORD_AW'(NUM_WORDS - 1));

  always_comb begin
    wu_ctl.bit_idx = first_bit_q;
    wu_ctl.lo      = (word_q == first_word_q) ? first_bit_q : 5'd0;
    wu_ctl.hi      = (word_q == last_word_q) ? last_bit_q : 5'd31;
    case (cmd_q)
      CMD_ALLOC: wu_ctl.op = WOP_FIND_SET;
      CMD_FREE:  wu_ctl.op = WOP_CLEAR;
      default:   wu_ctl.op = WOP_SET_RANGE;
    endcase
  end

  pba_word_unit u_word_unit (
    .ctl_i       (wu_ctl),
    .word_i      (ram_rdata),
    .word_o      (wu_word),
    .found_o     (wu_found),
    .found_bit_o (wu_found_bit)
  );

  pba_ram #(
    .WIDTH (32),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (word_q),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == WORD_AW'(NUM_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (cmd_q)
          CMD_ALLOC: state_d = hint_q[WORD_AW] ? S_RESP : S_READ;
          CMD_FREE:  state_d = (free_low || free_out) ? S_RESP : S_READ;
          default:   state_d = (map_reject || count_zero || first_out) ? S_RESP : S_READ;
        endcase
      end
      S_READ: state_d = S_MODIFY;
      S_MODIFY: begin
        case (cmd_q)
          CMD_ALLOC: state_d = (wu_found || scan_last) ? S_RESP : S_READ;
          CMD_FREE:  state_d = S_RESP;
          default:   state_d = (word_q == last_word_q) ? S_RESP : S_READ;
        endcase
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    word_d       = word_q;
    first_word_d = first_word_q;
    last_word_d  = last_word_q;
    first_bit_d  = first_bit_q;
    last_bit_d   = last_bit_q;
    hint_d       = hint_q;
    clr_d        = clr_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = word_q;
    ram_wdata    = wu_word;
    ram_re       = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = reset_word(clr_q);
        clr_d     = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          res_addr_d   = '0;
          res_status_d = ST_DONE;
        end
      end
      S_DECODE: begin
        case (cmd_q)
          CMD_ALLOC: begin
            word_d = hint_q[WORD_AW-1:0];
            if (hint_q[WORD_AW]) res_status_d = ST_NOFREE;
          end
          CMD_FREE: begin
            word_d      = free_pfn[PAGE_W-1:5];
            first_bit_d = free_pfn[4:0];
            if (free_low) res_status_d = ST_IGNORED;
          end
          default: begin
            word_d       = first_pfn[PAGE_W-1:5];
            first_word_d = first_pfn[PAGE_W-1:5];
            first_bit_d  = first_pfn[4:0];
            last_word_d  = last_page[PAGE_W-1:5];
            last_bit_d   = last_page[4:0];
            if (map_reject) res_status_d = ST_IGNORED;
          end
        endcase
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_MODIFY: begin
        case (cmd_q)
          CMD_ALLOC: begin
            if (wu_found) begin
              ram_we     = 1'b1;
              hint_d     = {1'b0, word_q};
              res_addr_d = 32'(64'({word_q, wu_found_bit}) << PAGE_SHIFT);
            end else if (scan_last) begin
              hint_d       = (WORD_AW+1)'(NUM_WORDS);
              res_status_d = ST_NOFREE;
            end else begin
              word_d = word_q + 1'b1;
            end
          end
          CMD_FREE: begin
            ram_we = 1'b1;
            // Pull the scan start back to a word that now has room.
            if ({1'b0, word_q} < hint_q) hint_d = {1'b0, word_q};
          end
          default: begin
            ram_we = 1'b1;
            if (word_q != last_word_q) word_d = word_q + 1'b1;
          end
        endcase
      end
      S_RESP: begin
        out_load = !out_valid_q || rsp_o.ready;
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q       <= cmd_e'(req_i.cmd);
      page_addr_q <= req_i.page_addr;
      base_q      <= req_i.region_base;
      len_q       <= req_i.region_length;
      type_q      <= req_i.region_type;
    end
    word_q       <= word_d;
    first_word_q <= first_word_d;
    last_word_q  <= last_word_d;
    first_bit_q  <= first_bit_d;
    last_bit_q   <= last_bit_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.alloc_addr = out_addr_q;
  assign rsp_o.status     = out_status_q;

  a_hint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= (WORD_AW+1)'(NUM_WORDS))
    else $error("scan hint beyond bitmap");

  a_range_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MODIFY && (cmd_q == CMD_RESERVE || cmd_q == CMD_MAP)) |->
    (word_q >= first_word_q && word_q <= last_word_q))
    else $error("reserve walk left its word range");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DECODE)
    else $error("accepted request not decoded");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_MODIFY))
    else $error("bitmap written outside clear or modify");

  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_DONE) |-> rsp_o.alloc_addr == 32'd0)
    else $error("nonzero address on failed or ignored request");

endmodule

`default_nettype wire

@@ tb/sv/tb_page_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_page_bitmap_allocator
// Self-checking bench for the first-fit page bitmap allocator. The bench keeps
// its own copy of the used/free bitmap and predicts each response as the
// request is accepted. It runs directed corner cases, then random traffic
// under three idle patterns, and finally fills the whole bitmap.
// ----------------------------------------------------------------------------

module tb_page_bitmap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  localparam int unsigned QUIET_LIMIT     = 300000;
  localparam int unsigned RSP_HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS     = 440;
  localparam logic [31:0] PAGE_BYTES      = 32'd1 << PAGE_SHIFT;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] page_addr;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [31:0] region_type;
  } page_req_t;

  class page_alloc_scoreboard;
    typedef struct {
      logic [31:0] alloc_addr;
      status_e     status;
    } page_rsp_t;

    logic [31:0] used_bitmap [NUM_WORDS];
    page_rsp_t   pending_rsp [$];
    logic [31:0] last_alloc_addr;
    status_e     last_status;
    int          errors;
    int          checked;
    int          nofree_cnt;
    int          ignored_cnt;
    int          cmd_cnt [4];

    function new();
      foreach (used_bitmap[w]) used_bitmap[w] = '0;
      foreach (cmd_cnt[c]) cmd_cnt[c] = 0;
      errors      = 0;
      checked     = 0;
      nofree_cnt  = 0;
      ignored_cnt = 0;
      mark_pages(64'd0, 64'(LOW_RESERVED_PAGES));
    endfunction

    // Set the bits of pages [first, stop), clipped to the bitmap.
    function void mark_pages(logic [63:0] first, logic [63:0] stop);
      logic [63:0] p;
      logic [63:0] left;
      int unsigned lo;
      int unsigned n;
      logic [31:0] mask;
      if (first >= 64'(TOTAL_PAGES)) return;
      if (stop > 64'(TOTAL_PAGES) || stop < first) stop = 64'(TOTAL_PAGES);
      p = first;
      while (p < stop) begin
        lo   = int'(p[4:0]);
        left = stop - p;
        n    = (left >= 64'(32 - lo)) ? 32 - lo : int'(left);
        mask = (n == 32) ? 32'hFFFF_FFFF : (((32'd1 << n) - 32'd1) << lo);
        used_bitmap[p[PAGE_W-1:5]] |= mask;
        p += 64'(n);
      end
    endfunction

    function void reserve_bytes(logic [63:0] base, logic [63:0] length);
      logic [63:0] first;
      logic [63:0] count;
      logic [63:0] stop;
      first = base >> PAGE_SHIFT;
      count = length >> PAGE_SHIFT;
      if (count == 64'd0) return;
      stop = first + count;
      if (stop < first) stop = 64'(TOTAL_PAGES);
      mark_pages(first, stop);
    endfunction

    function void note_request(page_req_t r);
      page_rsp_t   e;
      logic [63:0] page;
      logic [63:0] byte_addr;
      bit          found;
      e.alloc_addr = '0;
      e.status     = ST_DONE;
      found        = 1'b0;
      cmd_cnt[r.cmd]++;
      case (r.cmd)
        CMD_ALLOC: begin
          for (int w = 0; w < NUM_WORDS && !found; w++) begin
            if (used_bitmap[WORD_AW'(w)] != 32'hFFFF_FFFF) begin
              for (int b = 0; b < 32; b++) begin
                if (!used_bitmap[WORD_AW'(w)][5'(b)]) begin
                  used_bitmap[WORD_AW'(w)][5'(b)] = 1'b1;
                  page      = 64'(w) * 64'd32 + 64'(b);
                  byte_addr = page << PAGE_SHIFT;
                  e.alloc_addr = byte_addr[31:0];
                  found = 1'b1;
                  break;
                end
              end
            end
          end
          if (!found) e.status = ST_NOFREE;
        end
        CMD_FREE: begin
          if (r.page_addr < FREE_FLOOR) begin
            e.status = ST_IGNORED;
          end else begin
            page = 64'(r.page_addr) >> PAGE_SHIFT;
            if (page < 64'(TOTAL_PAGES)) used_bitmap[page[PAGE_W-1:5]][page[4:0]] = 1'b0;
          end
        end
        CMD_RESERVE: begin
          reserve_bytes(r.region_base, r.region_length);
        end
        default: begin
          if (r.region_base > 64'hFFFF_FFFF || r.region_length > 64'hFFFF_FFFF ||
              r.region_base < 64'(MAP_MIN_BASE) || r.region_type == MAP_USABLE_TYPE) begin
            e.status = ST_IGNORED;
          end else begin
            reserve_bytes(r.region_base, r.region_length);
          end
        end
      endcase
      last_alloc_addr = e.alloc_addr;
      last_status     = e.status;
      pending_rsp.push_back(e);
    endfunction

    function void check_response(logic [31:0] alloc_addr, logic [1:0] status);
      page_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("response with nothing pending: alloc_addr 0x%08h status %0d",
               alloc_addr, status);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      checked++;
      if (e.status == ST_NOFREE) nofree_cnt++;
      if (e.status == ST_IGNORED) ignored_cnt++;
      if (alloc_addr !== e.alloc_addr) begin
        $error("alloc_addr: expected 0x%08h, got 0x%08h", e.alloc_addr, alloc_addr);
        errors++;
      end
      if (status !== 2'(e.status)) begin
        $error("status: expected %0d, got %0d", 2'(e.status), status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pba_req_if req_if();
  pba_rsp_if rsp_if();

  page_bitmap_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  page_alloc_scoreboard sb;
  logic [31:0] live_pages [$];
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          stall_rsp    = 1'b0;
  int unsigned quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      sb.check_response(rsp_if.alloc_addr, rsp_if.status);
    end
  end

  // Response side: random back-pressure, plus one long hold on request.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_rsp) begin
        stall_rsp    = 1'b0;
        rsp_if.ready = 1'b0;
        repeat (RSP_HOLD_CYCLES) @(negedge clk_i);
      end
      rsp_if.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input page_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid         = 1'b1;
    req_if.cmd           = r.cmd;
    req_if.page_addr     = r.page_addr;
    req_if.region_base   = r.region_base;
    req_if.region_length = r.region_length;
    req_if.region_type   = r.region_type;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(r);
    if (r.cmd == CMD_ALLOC && sb.last_status == ST_DONE) live_pages.push_back(sb.last_alloc_addr);
    @(negedge clk_i);
  endtask

  task automatic put(input cmd_e c, input logic [31:0] pa, input logic [63:0] base,
                     input logic [63:0] length, input logic [31:0] rtype);
    page_req_t r;
    r.cmd           = c;
    r.page_addr     = pa;
    r.region_base   = base;
    r.region_length = length;
    r.region_type   = rtype;
    send_request(r);
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [63:0] page_span(int unsigned max_pages);
    return (64'($urandom_range(max_pages)) << PAGE_SHIFT) | 64'($urandom_range(PAGE_BYTES - 1));
  endfunction

  function automatic page_req_t random_request();
    page_req_t   r;
    int unsigned pick;
    int unsigned k;
    int unsigned idx;
    r.page_addr     = $urandom;
    r.region_base   = {$urandom, $urandom};
    r.region_length = {$urandom, $urandom};
    r.region_type   = $urandom;
    pick = $urandom_range(99);
    k    = $urandom_range(99);
    if (pick < 35) begin
      r.cmd = CMD_ALLOC;
    end else if (pick < 60) begin
      r.cmd = CMD_FREE;
      if (k < 70 && live_pages.size() > 0) begin
        idx = $urandom_range(live_pages.size() - 1);
        r.page_addr = live_pages[idx] | ($urandom & (PAGE_BYTES - 1));
        live_pages.delete(idx);
      end else if (k < 85) begin
        r.page_addr = $urandom_range(FREE_FLOOR - 1, 0);
      end
    end else if (pick < 80) begin
      r.cmd = CMD_RESERVE;
      if (k < 55) begin
        r.region_base   = {32'h0, $urandom};
        r.region_length = page_span(64);
      end else if (k < 80) begin
        // crowd the low pages so allocs have to scan past them
        r.region_base   = 64'($urandom_range(32'h0080_0000, FREE_FLOOR));
        r.region_length = page_span(24);
      end else begin
        r.region_base[63:32] = $urandom_range(32'hFFFF_FFFF, 1);
      end
    end else begin
      r.cmd           = CMD_MAP;
      r.region_base   = 64'($urandom_range(32'hFFFF_FFFF, MAP_MIN_BASE));
      r.region_length = page_span(48);
      if (r.region_type == MAP_USABLE_TYPE) r.region_type = 32'd2;
      if (k >= 65) begin
        case ($urandom_range(3))
          0: r.region_type = MAP_USABLE_TYPE;
          1: r.region_base = 64'($urandom_range(MAP_MIN_BASE - 1, 0));
          2: r.region_base[63:32] = $urandom_range(32'hFFFF_FFFF, 1);
          default: r.region_length[63:32] = $urandom_range(32'hFFFF_FFFF, 1);
        endcase
      end
    end
    return r;
  endfunction

  task automatic run_random(input int unsigned n, input int unsigned src_pct,
                            input int unsigned snk_pct, input int stall_at);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int i = 0; i < n; i++) begin
      if (i == stall_at) stall_rsp = 1'b1;
      send_request(random_request());
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    req_if.valid         = 1'b0;
    req_if.cmd           = CMD_ALLOC;
    req_if.page_addr     = '0;
    req_if.region_base   = '0;
    req_if.region_length = '0;
    req_if.region_type   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    put(CMD_FREE,    FREE_FLOOR,    '0,                     '0,                     '0);
    put(CMD_FREE,    FREE_FLOOR,    '0,                     '0,                     '0);
    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    put(CMD_FREE,    FREE_FLOOR - 1, '0,                    '0,                     '0);
    put(CMD_FREE,    '0,            '0,                     '0,                     '0);
    put(CMD_FREE,    '1,            '0,                     '0,                     '0);
    put(CMD_RESERVE, '0,            64'h0010_2000,          64'h3000,               '0);
    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    put(CMD_RESERVE, '0,            64'h0020_0000,          64'h0FFF,               '0);
    put(CMD_RESERVE, '0,            64'hFFFF_FFFF_FFFF_F000, '1,                    '0);
    put(CMD_RESERVE, '0,            64'h1_0000_0000,        64'h0010_0000,          '0);
    put(CMD_RESERVE, '0,            64'hFFFF_F000,          64'h2000,               '0);
    put(CMD_RESERVE, '0,            64'h0011_F000,          64'h0002_2000,          '0);
    put(CMD_MAP,     '0,            64'(MAP_MIN_BASE),      64'h2000,               32'd2);
    put(CMD_MAP,     '0,            64'h0200_0000,          64'h2000,               MAP_USABLE_TYPE);
    put(CMD_MAP,     '0,            64'(MAP_MIN_BASE) - 1,  64'h2000,               32'd2);
    put(CMD_MAP,     '0,            64'h1_0000_0000,        64'h2000,               32'd2);
    put(CMD_MAP,     '0,            64'h0200_0000,          64'h1_0000_0000,        32'd2);
    put(CMD_MAP,     '0,            64'hFFFF_FFFF,          64'hFFFF_FFFF,          '1);
    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    wait_drained();

    run_random(PHASE_ITEMS, 29, 55, 150);
    run_random(PHASE_ITEMS, 55, 29, -1);
    run_random(PHASE_ITEMS, 0, 0, 200);

    // Fill everything above the low pages, then work the allocator at the top.
    put(CMD_RESERVE, '0,            64'(FREE_FLOOR),        '1,                     '0);
    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    put(CMD_FREE,    32'h4000_0000, '0,                     '0,                     '0);
    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    put(CMD_FREE,    32'hFFFF_F000, '0,                     '0,                     '0);
    put(CMD_FREE,    FREE_FLOOR,    '0,                     '0,                     '0);
    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    put(CMD_ALLOC,   '0,            '0,                     '0,                     '0);
    wait_drained();
    repeat (40) @(negedge clk_i);

    $display("Requests: %0d alloc, %0d free, %0d range reserve, %0d map entry",
             sb.cmd_cnt[CMD_ALLOC], sb.cmd_cnt[CMD_FREE], sb.cmd_cnt[CMD_RESERVE],
             sb.cmd_cnt[CMD_MAP]);
    $display("Responses checked: %0d, of which %0d found no free page and %0d were filtered",
             sb.checked, sb.nofree_cnt, sb.ignored_cnt);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
